// ----- src/rrta_pkg.sv -----
package rrta_pkg;

  // Ring size default; the top level parameter overrides it
  localparam int RING_CELLS_DEF = 64;

  localparam int SPEED_W = 4;
  localparam int ID_W    = 8;
  localparam int BRAKE_W = 7;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BRAKE_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Operation codes carried on the input tuser
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE     = 1'd1;

  // One road cell; an empty cell is all zeros
  typedef struct packed {
    logic               occ;
    logic [SPEED_W-1:0] speed;
    logic [ID_W-1:0]    car_id;
  } cell_t;

  typedef struct packed {
    logic accept;     // take the input transfer
    logic cap_read;   // capture a read cell as the result
    logic cell_take;  // latch the swept cell, start the gap search
    logic scan_step;  // advance the gap search by one cell
    logic gap_d;      // gap is the current search distance
    logic gap_lim;    // gap is at least the search limit
    logic apply;      // compute the move, write next generation, advance sweep
    logic emit;       // load the output register
    logic clear_run;  // zero one row of the banks
    logic clear_all;  // zero both banks, not only the next one
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_in;
    logic cell_occ;
    logic limit_zero;
    logic scan_hit;
    logic scan_end;
    logic last_pos;
    logic out_free;
    logic clr_last;
  } stat_t;

endpackage

// ----- src/rrta_dp.sv -----
module rrta_dp #(
  parameter int RING_CELLS = rrta_pkg::RING_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rrta_pkg::cmd_t                     cmd,
  output rrta_pkg::stat_t                    st,
  input  logic [rrta_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [rrta_pkg::MODE_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rrta_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [rrta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrta_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rrta_pkg::*;

  localparam int AW = $clog2(RING_CELLS);
  localparam int SW = ((AW > SPEED_W) ? AW : SPEED_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(RING_CELLS - 1);

  // Input fields
  logic [IDX_W-1:0]   in_idx;
  logic               in_occ;
  logic [SPEED_W-1:0] in_speed;
  logic [ID_W-1:0]    in_id;
  logic [BRAKE_W-1:0] in_draw;
  logic               idx_ok_in;
  cell_t              load_cell;

  assign in_idx   = s_tdata[5:0];
  assign in_occ   = s_tdata[6];
  assign in_speed = s_tdata[10:7];
  assign in_id    = s_tdata[18:11];
  assign in_draw  = s_tdata[25:19];
  assign idx_ok_in = 32'(in_idx) < 32'(RING_CELLS);
  assign load_cell = in_occ ? cell_t'({1'b1, in_speed, in_id}) : cell_t'('0);

  // Configuration
  logic [SPEED_W-1:0] max_speed;
  logic [BRAKE_W-1:0] brake_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed     <= '0;
      brake_percent <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_SPEED) max_speed <= cfg_data[SPEED_W-1:0];
      if (cfg_index == REG_BRAKE) brake_percent <= cfg_data;
    end
  end

  // Two banks; sel marks the one holding the current generation
  cell_t       bank0 [RING_CELLS];
  cell_t       bank1 [RING_CELLS];
  cell_t       rd0, rd1, rd_cur;
  logic        sel;
  logic [AW-1:0] raddr, wr_addr, clr_addr, pos, c, c_first, c_next, dest_c;
  cell_t       wr_data;
  logic        load_we, apply_we, we0, we1;

  assign rd_cur = sel ? rd1 : rd0;

  always_ff @(posedge clk) begin
    if (we0) bank0[wr_addr] <= wr_data;
    rd0 <= bank0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we1) bank1[wr_addr] <= wr_data;
    rd1 <= bank1[raddr];
  end

  // Sweep state
  cell_t              cell_reg;
  logic [SPEED_W-1:0] v1, limit, d, g;
  logic [BRAKE_W-1:0] draw;
  logic               idx_ok;
  logic [4:0]         inc;
  logic [SPEED_W-1:0] v1_c, limit_c, v_cut, v_fin;
  logic               brake_hit;
  logic [SW-1:0]      sum;

  assign c_first = (pos == LAST) ? '0 : pos + AW'(1);
  assign c_next  = (c == LAST) ? '0 : c + AW'(1);

  assign inc     = {1'b0, rd_cur.speed} + 5'd1;
  assign v1_c    = (inc < {1'b0, max_speed}) ? inc[SPEED_W-1:0] : max_speed;
  assign limit_c = (32'(v1_c) > 32'(RING_CELLS - 1)) ? SPEED_W'(RING_CELLS - 1) : v1_c;

  assign v_cut     = (g < v1) ? g : v1;
  assign brake_hit = (brake_percent != '0) && (draw <= brake_percent);
  assign v_fin     = brake_hit ? ((v_cut != '0) ? v_cut - SPEED_W'(1) : '0) : v_cut;
  assign sum       = SW'(pos) + SW'(v_fin);
  assign dest_c    = (sum >= SW'(RING_CELLS)) ? AW'(sum - SW'(RING_CELLS)) : AW'(sum);

  assign load_we  = cmd.accept && (s_tuser == MODE_LOAD) && idx_ok_in;
  assign apply_we = cmd.apply && cell_reg.occ;

  always_comb begin
    raddr = c;
    if (cmd.accept) begin
      raddr = (s_tuser == MODE_UPDATE) ? pos : AW'(in_idx);
    end else if (cmd.cell_take) begin
      raddr = c_first;
    end else if (cmd.scan_step) begin
      raddr = c_next;
    end
  end

  always_comb begin
    wr_addr = clr_addr;
    wr_data = '0;
    if (load_we) begin
      wr_addr = AW'(in_idx);
      wr_data = load_cell;
    end else if (apply_we) begin
      wr_addr = dest_c;
      wr_data = cell_t'({1'b1, v_fin, cell_reg.car_id});
    end
  end

  assign we0 = (load_we && !sel) || (apply_we && sel) ||
               (cmd.clear_run && (cmd.clear_all || sel));
  assign we1 = (load_we && sel) || (apply_we && !sel) ||
               (cmd.clear_run && (cmd.clear_all || !sel));

  // Result registers
  cell_t            res;
  logic [IDX_W-1:0] res_dest;
  logic             res_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      sel      <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (cmd.accept && s_tuser == MODE_CLEAR) begin
        pos <= '0;
        sel <= 1'b0;
      end
      if (cmd.apply) begin
        pos <= (pos == LAST) ? '0 : pos + AW'(1);
        if (pos == LAST) sel <= ~sel;
      end
      if (cmd.clear_run) clr_addr <= (clr_addr == LAST) ? '0 : clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      draw     <= in_draw;
      idx_ok   <= idx_ok_in;
      res      <= (s_tuser == MODE_LOAD && idx_ok_in) ? load_cell : cell_t'('0);
      res_dest <= '0;
      res_done <= 1'b0;
    end
    if (cmd.cap_read) res <= idx_ok ? rd_cur : cell_t'('0);
    if (cmd.cell_take) begin
      cell_reg <= rd_cur;
      v1       <= v1_c;
      limit    <= limit_c;
      g        <= limit_c;
      c        <= c_first;
      d        <= '0;
    end
    if (cmd.scan_step) begin
      c <= c_next;
      d <= d + SPEED_W'(1);
    end
    if (cmd.gap_d) g <= d;
    if (cmd.gap_lim) g <= limit;
    if (cmd.apply) begin
      res      <= cell_reg.occ ? cell_t'({1'b1, v_fin, cell_reg.car_id}) : cell_t'('0);
      res_dest <= cell_reg.occ ? IDX_W'(dest_c) : '0;
      res_done <= (pos == LAST);
    end
  end

  // Output register
  cell_t            out_cell;
  logic [IDX_W-1:0] out_dest;
  logic             out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cell <= res;
      out_dest <= res_dest;
      out_done <= res_done;
    end
  end

  assign m_tdata = {5'd0, out_dest, out_cell.car_id, out_cell.speed, out_cell.occ};
  assign m_tlast = out_done;

  assign st.mode_in    = s_tuser;
  assign st.cell_occ   = rd_cur.occ;
  assign st.limit_zero = (limit_c == '0);
  assign st.scan_hit   = rd_cur.occ;
  assign st.scan_end   = ({1'b0, d} + 5'd1) == {1'b0, limit};
  assign st.last_pos   = (pos == LAST);
  assign st.out_free   = !m_tvalid || m_tready;
  assign st.clr_last   = (clr_addr == LAST);

endmodule

// ----- src/rrta_ctrl.sv -----
module rrta_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  rrta_pkg::stat_t st,
  output rrta_pkg::cmd_t  cmd
);
  import rrta_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CELL  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state, state_next;
  logic       clr_pending, clr_pending_next;
  logic       clr_all, clr_all_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    clr_pending_next = clr_pending;
    clr_all_next     = clr_all;
    cmd              = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_run = 1'b1;
        cmd.clear_all = clr_all;
        if (st.clr_last) begin
          clr_pending_next = 1'b0;
          clr_all_next     = 1'b0;
          state_next       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (st.mode_in)
            MODE_UPDATE: state_next = S_CELL;
            MODE_READ:   state_next = S_READ;
            MODE_CLEAR: begin
              clr_pending_next = 1'b1;
              clr_all_next     = 1'b1;
              state_next       = S_EMIT;
            end
            default:     state_next = S_EMIT;
          endcase
        end
      end
      S_READ: begin
        cmd.cap_read = 1'b1;
        state_next   = S_EMIT;
      end
      S_CELL: begin
        cmd.cell_take = 1'b1;
        state_next    = (st.cell_occ && !st.limit_zero) ? S_SCAN : S_APPLY;
      end
      S_SCAN: begin
        if (st.scan_hit) begin
          cmd.gap_d  = 1'b1;
          state_next = S_APPLY;
        end else if (st.scan_end) begin
          cmd.gap_lim = 1'b1;
          state_next  = S_APPLY;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_APPLY: begin
        cmd.apply        = 1'b1;
        clr_pending_next = st.last_pos;
        state_next       = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = clr_pending ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_pending <= 1'b1;
      clr_all     <= 1'b1;
    end else begin
      state       <= state_next;
      clr_pending <= clr_pending_next;
      clr_all     <= clr_all_next;
    end
  end

endmodule

// ----- src/ring_road_traffic_automaton.sv -----
// Single-lane ring road traffic automaton of RING_CELLS cells, one car per cell.
// Input stream: s_tuser carries the operation (load, update, read, clear), s_tdata
// the cell index, the car to load and the brake draw. Each input transfer gives
// exactly one output transfer on m_tdata; m_tlast marks the update that finished
// a sweep and committed the next generation.
// The gap search of an update of a car walks at most min(accelerated speed,
// RING_CELLS-1) cells. It reads the current generation bank one cell per cycle
// through its single read port, which sets the update time. Unless a clearing
// pass follows, the block takes the next input in the cycle after the result is
// loaded into the output register; it takes no new input before then.
// The last update of a sweep and a clear are followed by a clearing pass over
// the cell banks; no input is taken meanwhile.
// Reset (rst, synchronous) clears the configuration to zero and starts the same
// clearing pass before s_tready rises.
// Results wait in an output register; a stalled receiver holds the block in its
// final step until the register frees, and the next input is taken once the
// result is loaded there. Configuration writes take effect at once.
module ring_road_traffic_automaton #(
  parameter int RING_CELLS = rrta_pkg::RING_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [5:0] cell_index, [6] load_occupied, [10:7] load_speed,
  // [18:11] load_car_id, [25:19] random_draw, [31:26] zero
  input  logic [rrta_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [1:0] mode
  input  logic [rrta_pkg::MODE_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] cell_occupied, [4:1] cell_speed, [12:5] cell_car_id,
  // [18:13] destination_index, [23:19] zero
  output logic [rrta_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // generation_done
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [rrta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrta_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rrta_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Sequence each operation: accept, fetch, gap search, move, deliver, clear
  rrta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Cell banks, sweep position, speed arithmetic and output register
  rrta_dp #(
    .RING_CELLS (RING_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
